FILE: hw/rtl/ihex_pkg.sv
// shared types, codes and helpers for the intel hex record parser
`timescale 1ns / 1ps
`default_nettype none
package ihex_pkg;

  localparam int MaxLineCharsDef = 512;

  localparam int PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_WAIT    = 3'd0;
  localparam logic [PhaseW-1:0] PH_COUNT   = 3'd1;
  localparam logic [PhaseW-1:0] PH_ADDR_HI = 3'd2;
  localparam logic [PhaseW-1:0] PH_ADDR_LO = 3'd3;
  localparam logic [PhaseW-1:0] PH_TYPE    = 3'd4;
  localparam logic [PhaseW-1:0] PH_DATA    = 3'd5;
  localparam logic [PhaseW-1:0] PH_CSUM    = 3'd6;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_OK       = 3'd1,
    KIND_CSUM_ERR = 3'd2,
    KIND_EOF      = 3'd3,
    KIND_FORMAT   = 3'd4,
    KIND_IGNORED  = 3'd5
  } kind_e;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEGMENT = 8'h02;

  localparam logic [7:0] CHAR_COLON = 8'h3a;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [3:0]        nib_hi;
    logic              nib_second;
    logic [7:0]        bytes_left;
    logic [15:0]       line_addr;
    logic [15:0]       seg_base;
    logic [7:0]        type_field;
    logic [7:0]        sum;
    logic              finished;
  } state_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [20:0] byte_address;
    logic [7:0]  data_byte;
    logic [7:0]  record_kind;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ihex_decode.sv
// per-character next-state and result logic of the record parser
`timescale 1ns / 1ps
`default_nettype none
module ihex_decode import ihex_pkg::*; #(
  parameter int MaxLineChars = MaxLineCharsDef
) (
  input  state_t     st_i,
  input  logic [7:0] char_i,
  output state_t     st_o,
  output result_t    res_o
);

  localparam int LenW = 12;
  localparam logic [LenW-1:0] LenLimit = LenW'(MaxLineChars);

  hex_t            hex;
  logic [7:0]      b;
  logic [7:0]      left_dec;
  logic [LenW-1:0] line_len;

  always_comb begin
    hex      = hex_decode(char_i);
    b        = {st_i.nib_hi, hex.val};
    left_dec = st_i.bytes_left - 8'd1;
    line_len = LenW'({b, 1'b0}) + LenW'(11);

    st_o               = st_i;
    res_o.valid        = 1'b0;
    res_o.kind         = KIND_DATA;
    res_o.byte_address = '0;
    res_o.data_byte    = '0;
    res_o.record_kind  = st_i.type_field;

    if (st_i.finished) begin
      st_o = st_i;
    end else if (st_i.phase == PH_WAIT || st_i.phase > PH_CSUM) begin
      st_o.phase = PH_WAIT;
      if (char_i == CHAR_COLON) begin
        st_o.phase      = PH_COUNT;
        st_o.nib_hi     = '0;
        st_o.nib_second = 1'b0;
        st_o.bytes_left = '0;
        st_o.line_addr  = '0;
        st_o.type_field = '0;
        st_o.sum        = '0;
      end
    end else if (!hex.ok) begin
      res_o.valid = 1'b1;
      res_o.kind  = KIND_FORMAT;
      st_o.phase  = PH_WAIT;
      if (char_i == CHAR_COLON) begin
        st_o.phase      = PH_COUNT;
        st_o.nib_hi     = '0;
        st_o.nib_second = 1'b0;
        st_o.bytes_left = '0;
        st_o.line_addr  = '0;
        st_o.type_field = '0;
        st_o.sum        = '0;
      end
    end else if (!st_i.nib_second) begin
      st_o.nib_hi     = hex.val;
      st_o.nib_second = 1'b1;
    end else begin
      st_o.nib_second = 1'b0;
      st_o.sum        = st_i.sum + b;
      unique case (st_i.phase)
        PH_COUNT: begin
          st_o.bytes_left = b;
          if (line_len > LenLimit) begin
            st_o.phase  = PH_WAIT;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_FORMAT;
          end else begin
            st_o.phase = PH_ADDR_HI;
          end
        end
        PH_ADDR_HI: begin
          st_o.line_addr = {b, 8'h00};
          st_o.phase     = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          st_o.line_addr = {st_i.line_addr[15:8], b};
          st_o.phase     = PH_TYPE;
        end
        PH_TYPE: begin
          st_o.type_field = b;
          if (b == REC_SEGMENT) begin
            st_o.line_addr = '0;
          end
          st_o.phase = (st_i.bytes_left != 8'd0) ? PH_DATA : PH_CSUM;
        end
        PH_DATA: begin
          st_o.bytes_left = left_dec;
          if (left_dec == 8'd0) begin
            st_o.phase = PH_CSUM;
          end
          if (st_i.type_field == REC_DATA) begin
            res_o.valid        = 1'b1;
            res_o.kind         = KIND_DATA;
            res_o.byte_address = {1'b0, st_i.seg_base, 4'h0} + {5'd0, st_i.line_addr};
            res_o.data_byte    = b;
            st_o.line_addr     = st_i.line_addr + 16'd1;
          end else if (st_i.type_field == REC_SEGMENT) begin
            st_o.line_addr = {st_i.line_addr[7:0], b};
          end
        end
        default: begin
          st_o.phase  = PH_WAIT;
          res_o.valid = 1'b1;
          if (st_i.type_field == REC_DATA) begin
            res_o.kind = (st_o.sum == 8'd0) ? KIND_OK : KIND_CSUM_ERR;
          end else if (st_i.type_field == REC_EOF) begin
            if (st_o.sum != 8'd0) begin
              res_o.kind = KIND_CSUM_ERR;
            end else begin
              res_o.kind    = KIND_EOF;
              st_o.finished = 1'b1;
            end
          end else if (st_i.type_field == REC_SEGMENT) begin
            if (st_o.sum != 8'd0) begin
              res_o.kind = KIND_CSUM_ERR;
            end else begin
              res_o.kind    = KIND_OK;
              st_o.seg_base = st_i.line_addr;
            end
          end else begin
            res_o.kind = KIND_IGNORED;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/intel_hex_record_parser.sv
// top level of the intel hex record parser
// usage:
//   input channel: one ascii character per item on char_in_i, valid/ready
//   output channel: at most one result item per character, valid/ready;
//   kind_o tells data byte, record ok, checksum error, end of file,
//   format error or record ignored; byte_address_o and data_byte_o
//   carry the decoded byte for data items, record_kind_o the record type
//   throughput: one character per cycle, sustained unless the receiver stalls
//   after a character is accepted its result reaches the output through
//   the input register, then the result register
//   characters that give no result leave the result register untouched
//   when the receiver stalls the result register holds its item and the
//   input register fills; ready drops only once both are occupied
//   reset clears both registers and the parser returns to waiting for
//   a colon with a zero segment base
//   after a good end of file record every character is consumed silently
`timescale 1ns / 1ps
`default_nettype none
module intel_hex_record_parser import ihex_pkg::*; #(
  parameter int MaxLineChars = MaxLineCharsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [20:0]      byte_address_o,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       record_kind_o
);

  logic       in_vld_q;
  logic [7:0] char_q;
  logic       advance;
  state_t     st_q, st_d;
  result_t    res;
  logic       out_vld_q, out_vld_d;
  result_t    out_q;

  ihex_decode #(
    .MaxLineChars(MaxLineChars)
  ) u_decode (
    .st_i  (st_q),
    .char_i(char_q),
    .st_o  (st_d),
    .res_o (res)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign out_vld_d  = advance ? res.valid : (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      out_vld_q <= out_vld_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_in_i;
    end
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = out_q.kind;
  assign byte_address_o = out_q.byte_address;
  assign data_byte_o    = out_q.data_byte;
  assign record_kind_o  = out_q.record_kind;

endmodule
`default_nettype wire
